>>> design/sawc_pkg.sv
package sawc_pkg;
  // sequencer states
  typedef enum logic [7:0] {
    ST_CLEAR  = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_LOOKUP = 8'b0000_0100,
    ST_EVICT  = 8'b0000_1000,
    ST_FILL   = 8'b0001_0000,
    ST_SERVE  = 8'b0010_0000,
    ST_READ   = 8'b0100_0000,
    ST_OUT    = 8'b1000_0000
  } state_t;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;
endpackage

>>> design/sawc_ram.sv
module sawc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> design/set_assoc_writeback_cache.sv
// Channel | Dir | tdata (low bit up)                                        | tuser
// s_axis  | in  | byte_address[15:0], write_data[23:16]                      | opcode
// m_axis  | out | read_data[7:0], hit_total[39:8], miss_total[71:40]         | was_hit
// After reset a clearing pass writes main memory and line state to zero, one entry
// a cycle, before the first word is taken.
// Hit: lookup reads one way a cycle from the line state RAM, then SERVE, READ and OUT
// access the line byte and register the result before the next word is taken.
// Miss: a dirty victim is first written back, then the block is filled, byte by byte,
// set by the single byte ports of line storage and main memory.
// s_tready is low while a word is in work; the result waits in an output register,
// and the next word stalls before its result until that register is free.
module set_assoc_writeback_cache #(
  parameter int NUM_SETS    = 32,
  parameter int NUM_WAYS    = 8,
  parameter int BLOCK_BYTES = 64,
  parameter int ADDR_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [((ADDR_BITS + 15) / 8) * 8 - 1:0] s_tdata,  // byte_address, write_data
  input  logic        s_tuser,  // opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,  // read_data, hit_total, miss_total
  output logic        m_tuser   // was_hit
);
  import sawc_pkg::*;

  localparam int OB  = $clog2(BLOCK_BYTES);
  localparam int SB  = $clog2(NUM_SETS);
  localparam int WB  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int TB  = ADDR_BITS - OB - SB;
  localparam int NL  = NUM_SETS * NUM_WAYS;
  localparam int LB  = $clog2(NL);
  localparam int MD  = 1 << ADDR_BITS;
  localparam int MW  = TB + 34;
  localparam int CLR = (NL > MD) ? NL : MD;
  localparam int CW  = ADDR_BITS + 2;

  state_t state;
  logic              op;
  logic [ADDR_BITS-1:0] addr;
  logic [7:0]        wbyte;
  logic [WB:0]       wcnt;
  logic [OB:0]       bcnt;
  logic [CW-1:0]     ccnt;
  logic              hit, found;
  logic [WB-1:0]     way, best;
  logic [31:0]       best_stamp, lstamp;
  logic [TB-1:0]     best_tag;
  logic              best_dirty;
  logic [31:0]       stamp_counter, hits, misses;
  logic [31:0]       o_hits, o_misses;
  logic              o_hit;
  logic [7:0]        rd_byte;

  wire [OB-1:0] off  = addr[OB-1:0];
  wire [SB-1:0] set  = addr[OB+SB-1:OB];
  wire [TB-1:0] atag = addr[ADDR_BITS-1:OB+SB];
  wire [WB-1:0] wsel = wcnt[WB-1:0];
  wire [WB-1:0] pway = WB'(wcnt - 1'b1);
  wire [LB-1:0] lsel = LB'(set * NUM_WAYS + wsel);
  wire [LB-1:0] line = LB'(set * NUM_WAYS + way);

  // line storage, main memory and line state {stamp, tag, dirty, valid}
  logic              l_we, m_we, meta_we;
  logic [LB+OB-1:0]  l_wa, l_ra;
  logic [ADDR_BITS-1:0] m_wa, m_ra;
  logic [7:0]        l_wd, m_wd, l_rd, m_rd;
  logic [LB-1:0]     meta_wa;
  logic [MW-1:0]     meta_wd, meta_rd;

  sawc_ram #(.WIDTH(8), .DEPTH(NL * BLOCK_BYTES)) u_lines (
    .clk, .we(l_we), .waddr(l_wa), .wdata(l_wd), .raddr(l_ra), .rdata(l_rd));
  sawc_ram #(.WIDTH(8), .DEPTH(MD)) u_main (
    .clk, .we(m_we), .waddr(m_wa), .wdata(m_wd), .raddr(m_ra), .rdata(m_rd));
  sawc_ram #(.WIDTH(MW), .DEPTH(NL)) u_meta (
    .clk, .we(meta_we), .waddr(meta_wa), .wdata(meta_wd), .raddr(lsel), .rdata(meta_rd));

  // line state of the way addressed in the previous cycle
  wire          e_valid = meta_rd[0];
  wire          e_dirty = meta_rd[1];
  wire [TB-1:0] e_tag   = meta_rd[TB+1:2];
  wire [31:0]   e_stamp = meta_rd[MW-1:TB+2];

  // byte counter: each byte is written in the cycle after it is read
  wire [OB-1:0] bidx  = bcnt[OB-1:0];
  wire [OB-1:0] bprev = OB'(bcnt - 1'b1);
  wire [ADDR_BITS-1:0] old_base = {best_tag, set, {OB{1'b0}}};
  wire [ADDR_BITS-1:0] new_base = {atag, set, {OB{1'b0}}};

  always_comb begin
    l_we = 1'b0; m_we = 1'b0; meta_we = 1'b0;
    l_wa = {line, bprev}; l_wd = m_rd;
    m_wa = ccnt[ADDR_BITS-1:0]; m_wd = 8'd0;
    l_ra = {line, bidx}; m_ra = new_base | ADDR_BITS'(bidx);
    meta_wa = line; meta_wd = '0;
    unique case (state)
      ST_CLEAR: begin
        m_we = 1'b1;
        meta_we = (ccnt < CW'(NL));
        meta_wa = LB'(ccnt);
      end
      ST_EVICT: begin
        m_we = (bcnt != 0);
        m_wa = old_base | ADDR_BITS'(bprev);
        m_wd = l_rd;
      end
      ST_FILL: begin
        l_we = (bcnt != 0);
        meta_we = (bcnt == (OB+1)'(BLOCK_BYTES));
        meta_wd = {stamp_counter + 32'd1, atag, 1'b0, 1'b1};
      end
      ST_SERVE: begin
        l_we = (op == OP_WRITE);
        l_wa = {line, off};
        l_wd = wbyte;
        l_ra = {line, off};
        meta_we = (op == OP_WRITE);
        meta_wd = {lstamp, atag, 1'b1, 1'b1};
      end
      ST_READ, ST_OUT: l_ra = {line, off};
      default: ;
    endcase
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tdata  = {o_misses, o_hits, rd_byte};
  assign m_tuser  = o_hit;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR; ccnt <= '0;
      stamp_counter <= '0; hits <= '0; misses <= '0; m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != ST_OUT) m_tvalid <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          ccnt <= ccnt + 1'b1;
          if (ccnt == CW'(CLR - 1)) state <= ST_IDLE;
        end
        ST_IDLE: if (s_tvalid) begin
          addr <= s_tdata[ADDR_BITS-1:0]; wbyte <= s_tdata[ADDR_BITS +: 8];
          op <= s_tuser; wcnt <= '0; found <= 1'b0;
          best <= '0; best_stamp <= '1; state <= ST_LOOKUP;
        end
        ST_LOOKUP: begin
          // one way per cycle: tag match and oldest stamp
          wcnt <= wcnt + 1'b1;
          if (wcnt != 0 && wcnt <= (WB+1)'(NUM_WAYS)) begin
            if (!found && e_valid && e_tag == atag) begin
              found <= 1'b1; way <= pway; lstamp <= e_stamp;
            end
            if (wcnt == 1 || e_stamp < best_stamp) begin
              best_stamp <= e_stamp; best <= pway; best_tag <= e_tag;
              best_dirty <= e_valid && e_dirty;
            end
          end
          if (wcnt == (WB+1)'(NUM_WAYS + 1)) begin
            bcnt <= '0;
            if (found) begin
              hit <= 1'b1; hits <= hits + 1'b1;
              state <= ST_SERVE;
            end else begin
              hit <= 1'b0; misses <= misses + 1'b1;
              way <= best;
              state <= best_dirty ? ST_EVICT : ST_FILL;
            end
          end
        end
        ST_EVICT: begin
          if (bcnt == (OB+1)'(BLOCK_BYTES)) begin
            bcnt <= '0; state <= ST_FILL;
          end else begin
            bcnt <= bcnt + 1'b1;
          end
        end
        ST_FILL: begin
          bcnt <= bcnt + 1'b1;
          if (bcnt == (OB+1)'(BLOCK_BYTES)) begin
            stamp_counter <= stamp_counter + 1'b1;
            lstamp <= stamp_counter + 1'b1;
            state <= ST_SERVE;
          end
        end
        ST_SERVE: state <= ST_READ;
        ST_READ: state <= ST_OUT;
        ST_OUT: if (!m_tvalid || m_tready) begin
          rd_byte <= l_rd; o_hit <= hit; o_hits <= hits; o_misses <= misses;
          m_tvalid <= 1'b1; state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !s_tready) else $error("ready while busy");
  a_one_state: assert property (@(posedge clk) disable iff (rst)
    $onehot(state)) else $error("state not one-hot");
  a_count: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready) |=> $stable(hits) || $stable(misses))
    else $error("both counters moved");
`endif
endmodule

>>> test/cache_checker.sv
`timescale 1ns / 1ps

module cache_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [71:0] m_tdata,
  input  logic        m_tuser,
  output int          errors,
  output int          pending
);
  import sawc_pkg::*;

  localparam int SETS = 32;
  localparam int WAYS = 8;
  localparam int BLK  = 64;

  typedef struct packed {
    logic [7:0]  rd;
    logic        hit;
    logic [31:0] hits;
    logic [31:0] misses;
  } access_result_t;

  logic        vld   [SETS*WAYS];
  logic        dty   [SETS*WAYS];
  logic [4:0]  tagm  [SETS*WAYS];
  logic [31:0] stamp [SETS*WAYS];
  logic [7:0]  lbytes[SETS*WAYS*BLK];
  logic [7:0]  mem   [65536];
  logic [31:0] stamp_ctr, hit_ctr, miss_ctr;
  access_result_t expected_q[$];

  // cache model: one access, returns the result word
  function automatic access_result_t cache_access(logic op, logic [15:0] a, logic [7:0] d);
    access_result_t r;
    int set, off, ln, w, bw;
    logic [4:0] tg;
    logic [15:0] base;
    logic hit;
    off = int'(a[5:0]);
    set = int'(a[10:6]);
    tg  = a[15:11];
    hit = 0;
    ln  = 0;
    for (w = 0; w < WAYS; w++)
      if (!hit && vld[set*WAYS+w] && tagm[set*WAYS+w] == tg) begin
        hit = 1;
        ln = set*WAYS + w;
      end
    if (hit) hit_ctr++;
    else begin
      miss_ctr++;
      // FIFO victim: smallest stamp, lowest way on ties
      bw = 0;
      for (w = 1; w < WAYS; w++)
        if (stamp[set*WAYS+w] < stamp[set*WAYS+bw]) bw = w;
      ln = set*WAYS + bw;
      if (vld[ln] && dty[ln]) begin
        base = {tagm[ln], set[4:0], 6'd0};
        for (w = 0; w < BLK; w++) mem[base + w] = lbytes[ln*BLK + w];
      end
      base = {a[15:6], 6'd0};
      for (w = 0; w < BLK; w++) lbytes[ln*BLK + w] = mem[base + w];
      stamp_ctr++;
      stamp[ln] = stamp_ctr;
      dty[ln] = 0;
      vld[ln] = 1;
      tagm[ln] = tg;
    end
    if (op == OP_WRITE) begin
      lbytes[ln*BLK + off] = d;
      dty[ln] = 1;
    end
    r.rd = lbytes[ln*BLK + off];
    r.hit = hit;
    r.hits = hit_ctr;
    r.misses = miss_ctr;
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    access_result_t e, got;
    if (rst) begin
      for (int i = 0; i < SETS*WAYS; i++) begin
        vld[i] = 0; dty[i] = 0; stamp[i] = 0;
      end
      for (int i = 0; i < 65536; i++) mem[i] = 0;
      stamp_ctr = 0; hit_ctr = 0; miss_ctr = 0;
      errors = 0;
      expected_q.delete();
    end else begin
      if (s_tvalid && s_tready)
        expected_q.push_back(cache_access(s_tuser, s_tdata[15:0], s_tdata[23:16]));
      if (m_tvalid && m_tready) begin
        got = '{m_tdata[7:0], m_tuser, m_tdata[39:8], m_tdata[71:40]};
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("checker: unexpected word %h", got);
        end else begin
          e = expected_q.pop_front();
          if (got != e) begin
            errors++;
            if (errors <= 10)
              $display("checker: mismatch rd %h/%h hit %b/%b hits %0d/%0d misses %0d/%0d",
                       e.rd, got.rd, e.hit, got.hit, e.hits, got.hits,
                       e.misses, got.misses);
          end
        end
      end
    end
  end
endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
  import sawc_pkg::*;

  localparam int WATCHDOG = 200000;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        s_tuser = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [71:0] m_tdata;
  logic        m_tuser;
  int          errors, pending;
  int          idle_cycles = 0;

  always #5 clk = ~clk;

  set_assoc_writeback_cache DUT (.*);
  cache_checker chk (.*);

  // watchdog on cycles with no accepted word
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // receiver drops m_tready for a random gap before each word, or not at all
  initial begin
    int gap;
    @(negedge clk);
    forever begin
      gap = $urandom_range(0, 3);
      if (gap != 0) begin
        m_tready <= 0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // sender drops s_tvalid for a random gap after each word, or not at all
  task automatic send_word(logic op, logic [15:0] a, logic [7:0] d);
    int gap;
    s_tvalid <= 1;
    s_tuser <= op;
    s_tdata <= {d, a};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    gap = $urandom_range(0, 3);
    if (gap != 0) begin
      s_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
  endtask

  initial begin
    logic [15:0] a;
    logic [4:0] hot_set;
    repeat (10) @(negedge clk);
    rst <= 0;
    // directed: extremes, fill all ways of set 0, evict dirty, re-read
    send_word(OP_READ, 16'h0000, 8'h00);
    send_word(OP_WRITE, 16'hFFFF, 8'hFF);
    send_word(OP_READ, 16'hFFFF, 8'h00);
    send_word(OP_WRITE, 16'h0000, 8'hA5);
    send_word(OP_WRITE, 16'h0000, 8'h5A);
    for (int t = 1; t < 10; t++) send_word(OP_WRITE, {t[4:0], 5'd0, 6'd63}, t[7:0]);
    send_word(OP_READ, 16'h0000, 8'h00);
    send_word(OP_READ, 16'h003F, 8'h00);
    send_word(OP_READ, {5'd1, 5'd0, 6'd63}, 8'h00);
    // pause until everything has drained
    s_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    // random: mostly a few hot sets with many tags to force evictions
    for (int i = 0; i < 1100; i++) begin
      hot_set = 5'($urandom_range(0, 3));
      case ($urandom_range(0, 3))
        0: a = 16'($urandom);
        1: a = {5'($urandom), hot_set, 6'($urandom)};
        default: a = {2'd0, 3'($urandom), hot_set, 6'($urandom_range(0, 3))};
      endcase
      send_word(1'($urandom), a, 8'($urandom));
    end
    s_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (errors == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end
endmodule
